>>> rtl/core/vgdc_pkg.sv
// Package for the vector grid divergence/curl block: widths, register codes,
// queue word type and back-end states. No dependencies.
package vgdc_pkg;

  localparam int DEF_DIM_X = 32;
  localparam int DEF_DIM_Y = 32;
  localparam int DEF_DIM_Z = 32;
  localparam int CELL_W    = 5;
  localparam int COMP_W    = 32;
  localparam int HINV_W    = 24;
  localparam int SIZE_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = 33;
  localparam int PROD_W    = DIFF_W + HINV_W + 1;
  localparam int ACC_W     = 60;
  localparam int QDEPTH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HINV_X = 3'd0,
    REG_HINV_Y = 3'd1,
    REG_HINV_Z = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_READ,
    BE_MUL,
    BE_SUM,
    BE_OUT
  } be_state_t;

  // one classified word from the front end; neighbor coordinates already clamped
  typedef struct packed {
    logic              query;
    logic              bad;
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic [CELL_W-1:0] z;
    logic [CELL_W-1:0] xl;
    logic [CELL_W-1:0] xr;
    logic [CELL_W-1:0] yd;
    logic [CELL_W-1:0] yu;
    logic [CELL_W-1:0] zb;
    logic [CELL_W-1:0] zf;
    logic [COMP_W-1:0] vx;
    logic [COMP_W-1:0] vy;
    logic [COMP_W-1:0] vz;
  } item_t;

endpackage

>>> rtl/core/vgdc_front.sv
// Front end: takes input words, checks indices against the grid size and
// computes the clamped neighbor coordinates into a queue. Uses vgdc_pkg.
module vgdc_front
  import vgdc_pkg::*;
#(
  parameter int MAX_DIM_X = DEF_DIM_X,
  parameter int MAX_DIM_Y = DEF_DIM_Y,
  parameter int MAX_DIM_Z = DEF_DIM_Z
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [CELL_W-1:0] in_cell_x,
  input  logic [CELL_W-1:0] in_cell_y,
  input  logic [CELL_W-1:0] in_cell_z,
  input  logic [COMP_W-1:0] in_vec_x,
  input  logic [COMP_W-1:0] in_vec_y,
  input  logic [COMP_W-1:0] in_vec_z,
  input  logic [SIZE_W-1:0] size_x,
  input  logic [SIZE_W-1:0] size_y,
  input  logic [SIZE_W-1:0] size_z,
  output logic              q_valid,
  input  logic              q_ready,
  output item_t             q_word
);

  localparam int QPTR_W = $clog2(QDEPTH);

  item_t             q_mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;
  logic [8:0]        nx, ny, nz;
  item_t             w;

  function automatic logic [8:0] eff(input logic [SIZE_W-1:0] s, input int mx);
    logic [8:0] m;
    m = 9'(mx);
    if (s == '0) return 9'd1;
    if (9'(s) > m) return m;
    return 9'(s);
  endfunction

  always_comb begin
    nx = eff(size_x, MAX_DIM_X);
    ny = eff(size_y, MAX_DIM_Y);
    nz = eff(size_z, MAX_DIM_Z);
    w.query = (in_opcode == OP_QUERY);
    w.bad   = (9'(in_cell_x) >= nx) || (9'(in_cell_y) >= ny) || (9'(in_cell_z) >= nz);
    w.x  = in_cell_x;
    w.y  = in_cell_y;
    w.z  = in_cell_z;
    w.xl = (in_cell_x != '0) ? in_cell_x - 1'b1 : in_cell_x;
    w.yd = (in_cell_y != '0) ? in_cell_y - 1'b1 : in_cell_y;
    w.zb = (in_cell_z != '0) ? in_cell_z - 1'b1 : in_cell_z;
    w.xr = (9'(in_cell_x) + 9'd1 < nx) ? in_cell_x + 1'b1 : in_cell_x;
    w.yu = (9'(in_cell_y) + 9'd1 < ny) ? in_cell_y + 1'b1 : in_cell_y;
    w.zf = (9'(in_cell_z) + 9'd1 < nz) ? in_cell_z + 1'b1 : in_cell_z;
    w.vx = in_vec_x;
    w.vy = in_vec_y;
    w.vz = in_vec_z;
  end

  assign in_ready = (cnt_r != (QPTR_W+1)'(QDEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_word   = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) q_mem_r[wp_r] <= w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (in_valid && in_ready) wp_r <= wp_r + 1'b1;
      if (q_valid && q_ready)   rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(in_valid && in_ready) - (QPTR_W+1)'(q_valid && q_ready);
    end
  end

endmodule

>>> rtl/core/vgdc_back.sv
// Back end: owns the grid memory, performs writes, reads six neighbors for a
// query, multiplies differences by spacing factors and rounds. Uses vgdc_pkg.
module vgdc_back
  import vgdc_pkg::*;
#(
  parameter int MAX_DIM_X = DEF_DIM_X,
  parameter int MAX_DIM_Y = DEF_DIM_Y,
  parameter int MAX_DIM_Z = DEF_DIM_Z
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  item_t             q_word,
  input  logic [HINV_W-1:0] hinv_x,
  input  logic [HINV_W-1:0] hinv_y,
  input  logic [HINV_W-1:0] hinv_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [COMP_W-1:0] out_divergence,
  output logic [COMP_W-1:0] out_curl_x,
  output logic [COMP_W-1:0] out_curl_y,
  output logic [COMP_W-1:0] out_curl_z,
  output logic              out_index_error,
  output logic              out_saturated
);

  localparam int XW = $clog2(MAX_DIM_X);
  localparam int YW = $clog2(MAX_DIM_Y);
  localparam int ZW = $clog2(MAX_DIM_Z);
  localparam int AW = XW + YW + ZW;
  localparam int DEPTH = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;

  logic [3*COMP_W-1:0] mem [DEPTH];
  logic [3*COMP_W-1:0] rd_r;

  be_state_t st_r, st_nxt;
  item_t     it_r;
  logic [2:0] rc_r, rc_nxt;   // read issue count
  logic [3:0] mc_r;           // multiply step
  logic       rd_v_r;
  logic [2:0] rd_tag_r;
  logic signed [COMP_W-1:0] nb_r [6][3];
  logic signed [PROD_W-1:0] prd_r;
  logic signed [ACC_W-1:0]  acc_r [4];

  logic [AW-1:0] raddr, waddr;
  logic          mem_we, mem_re;
  logic [CELL_W-1:0] ax, ay, az;

  function automatic logic [AW-1:0] addr(input logic [CELL_W-1:0] x,
                                         input logic [CELL_W-1:0] y,
                                         input logic [CELL_W-1:0] z);
    logic [AW-1:0] a;
    a = AW'(x) + AW'(MAX_DIM_X) * (AW'(y) + AW'(MAX_DIM_Y) * AW'(z));
    return a;
  endfunction

  always_comb begin
    ax = it_r.x; ay = it_r.y; az = it_r.z;
    case (rc_r)
      3'd0: ax = it_r.xl;
      3'd1: ax = it_r.xr;
      3'd2: ay = it_r.yd;
      3'd3: ay = it_r.yu;
      3'd4: az = it_r.zb;
      default: az = it_r.zf;
    endcase
    raddr = addr(ax, ay, az);
    waddr = addr(it_r.x, it_r.y, it_r.z);
  end

  assign mem_we = (st_r == BE_READ) && !it_r.query && !it_r.bad;
  assign mem_re = (st_r == BE_READ) && it_r.query && !it_r.bad && (rc_r < 3'd6);

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= {it_r.vx, it_r.vy, it_r.vz};
    if (mem_re) rd_r <= mem[raddr];
  end

  // multiply operand select: one difference times one factor per cycle
  logic signed [DIFF_W-1:0] dsel;
  logic [HINV_W-1:0]        hsel;
  always_comb begin
    case (mc_r)
      4'd0: begin dsel = DIFF_W'(nb_r[1][0]) - DIFF_W'(nb_r[0][0]); hsel = hinv_x; end
      4'd1: begin dsel = DIFF_W'(nb_r[3][1]) - DIFF_W'(nb_r[2][1]); hsel = hinv_y; end
      4'd2: begin dsel = DIFF_W'(nb_r[5][2]) - DIFF_W'(nb_r[4][2]); hsel = hinv_z; end
      4'd3: begin dsel = DIFF_W'(nb_r[3][2]) - DIFF_W'(nb_r[2][2]); hsel = hinv_y; end
      4'd4: begin dsel = DIFF_W'(nb_r[5][1]) - DIFF_W'(nb_r[4][1]); hsel = hinv_z; end
      4'd5: begin dsel = DIFF_W'(nb_r[5][0]) - DIFF_W'(nb_r[4][0]); hsel = hinv_z; end
      4'd6: begin dsel = DIFF_W'(nb_r[1][2]) - DIFF_W'(nb_r[0][2]); hsel = hinv_x; end
      4'd7: begin dsel = DIFF_W'(nb_r[1][1]) - DIFF_W'(nb_r[0][1]); hsel = hinv_x; end
      default: begin dsel = DIFF_W'(nb_r[3][0]) - DIFF_W'(nb_r[2][0]); hsel = hinv_y; end
    endcase
  end

  // the product of step n-1 is accumulated during step n
  logic [3:0] pc_r;
  logic       pv_r;

  function automatic logic [COMP_W:0] rnd(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-17:0] q;
    logic sat;
    t = v + ACC_W'(32768);
    q = t[ACC_W-1:16];
    sat = (q > (ACC_W-16)'(32'sh7fffffff)) || (q < -(ACC_W-16)'(33'sh080000000));
    if (q > (ACC_W-16)'(32'sh7fffffff)) return {1'b1, 32'h7fffffff};
    if (sat) return {1'b1, 32'h80000000};
    return {1'b0, q[COMP_W-1:0]};
  endfunction

  logic [COMP_W:0] r0, r1, r2, r3;
  always_comb begin
    r0 = rnd(acc_r[0]);
    r1 = rnd(acc_r[1]);
    r2 = rnd(acc_r[2]);
    r3 = rnd(acc_r[3]);
  end

  assign q_ready = (st_r == BE_IDLE);

  always_comb begin
    st_nxt = st_r;
    rc_nxt = rc_r;
    case (st_r)
      BE_IDLE: if (q_valid) begin st_nxt = BE_READ; rc_nxt = '0; end
      BE_READ: begin
        if (!it_r.query || it_r.bad) st_nxt = BE_OUT;
        else if (rd_v_r && rd_tag_r == 3'd5) st_nxt = BE_MUL;
        if (rc_r < 3'd6) rc_nxt = rc_r + 1'b1;
      end
      BE_MUL: if (mc_r == 4'd8) st_nxt = BE_SUM;
      BE_SUM: if (!pv_r) st_nxt = BE_OUT;
      BE_OUT: if (out_ready) st_nxt = BE_IDLE;
      default: st_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BE_IDLE;
      rc_r   <= '0;
      mc_r   <= '0;
      rd_v_r <= 1'b0;
      pv_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      rc_r   <= rc_nxt;
      rd_v_r <= mem_re;
      pv_r   <= (st_r == BE_MUL);
      if (st_r == BE_MUL) mc_r <= mc_r + 1'b1;
      else mc_r <= '0;
      if (st_nxt == BE_OUT && st_r != BE_OUT) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == BE_IDLE && q_valid) it_r <= q_word;
    rd_tag_r <= rc_r;
    if (rd_v_r) begin
      nb_r[rd_tag_r][0] <= rd_r[3*COMP_W-1:2*COMP_W];
      nb_r[rd_tag_r][1] <= rd_r[2*COMP_W-1:COMP_W];
      nb_r[rd_tag_r][2] <= rd_r[COMP_W-1:0];
    end
    prd_r <= dsel * $signed({1'b0, hsel});
    pc_r  <= mc_r;
    if (st_r == BE_READ) begin
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end else if (pv_r) begin
      case (pc_r)
        4'd0, 4'd1, 4'd2: acc_r[0] <= acc_r[0] + ACC_W'(prd_r);
        4'd3: acc_r[1] <= acc_r[1] + ACC_W'(prd_r);
        4'd4: acc_r[1] <= acc_r[1] - ACC_W'(prd_r);
        4'd5: acc_r[2] <= acc_r[2] + ACC_W'(prd_r);
        4'd6: acc_r[2] <= acc_r[2] - ACC_W'(prd_r);
        4'd7: acc_r[3] <= acc_r[3] + ACC_W'(prd_r);
        default: acc_r[3] <= acc_r[3] - ACC_W'(prd_r);
      endcase
    end
  end

  logic q_ok;
  assign q_ok = it_r.query && !it_r.bad;
  assign out_divergence  = q_ok ? r0[COMP_W-1:0] : '0;
  assign out_curl_x      = q_ok ? r1[COMP_W-1:0] : '0;
  assign out_curl_y      = q_ok ? r2[COMP_W-1:0] : '0;
  assign out_curl_z      = q_ok ? r3[COMP_W-1:0] : '0;
  assign out_index_error = it_r.bad;
  assign out_saturated   = q_ok && (r0[COMP_W] || r1[COMP_W] || r2[COMP_W] || r3[COMP_W]);

endmodule

>>> rtl/core/vector_grid_divergence_curl_top.sv
// Top level of the vector grid divergence/curl block: config registers,
// front end, back end. Uses vgdc_pkg, vgdc_front, vgdc_back.
//
//  channel | direction | handshake      | payload
//  in_     | input     | valid/ready    | opcode, cell x/y/z, vec x/y/z
//  out_    | output    | valid/ready    | divergence, curl x/y/z, flags
//  cfg_    | input     | write enable   | index, 24-bit data
//
// A write passes the back end through its read and out states; a query through
// read, multiply, sum and out, its pace set by the six reads of the single-port
// grid memory and one shared multiplier for the nine products. A two-word queue
// lets the front accept while the back works.
// Reset restores the register defaults; grid contents stay undefined.
// A stalled result holds the back end; the queue keeps taking words until full.
module vector_grid_divergence_curl_top
  import vgdc_pkg::*;
#(
  parameter int MAX_DIM_X = DEF_DIM_X,
  parameter int MAX_DIM_Y = DEF_DIM_Y,
  parameter int MAX_DIM_Z = DEF_DIM_Z
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_opcode,
  input  logic [CELL_W-1:0]    in_cell_x,
  input  logic [CELL_W-1:0]    in_cell_y,
  input  logic [CELL_W-1:0]    in_cell_z,
  input  logic [COMP_W-1:0]    in_vec_x,
  input  logic [COMP_W-1:0]    in_vec_y,
  input  logic [COMP_W-1:0]    in_vec_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COMP_W-1:0]    out_divergence,
  output logic [COMP_W-1:0]    out_curl_x,
  output logic [COMP_W-1:0]    out_curl_y,
  output logic [COMP_W-1:0]    out_curl_z,
  output logic                 out_index_error,
  output logic                 out_saturated,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [HINV_W-1:0]    cfg_data
);

  logic [HINV_W-1:0] hx_r, hy_r, hz_r;
  logic [SIZE_W-1:0] sx_r, sy_r, sz_r;
  logic              q_valid, q_ready;
  item_t             q_word;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r <= HINV_W'(32768);
      hy_r <= HINV_W'(32768);
      hz_r <= HINV_W'(32768);
      sx_r <= SIZE_W'(32);
      sy_r <= SIZE_W'(32);
      sz_r <= SIZE_W'(32);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HINV_X: hx_r <= cfg_data;
        REG_HINV_Y: hy_r <= cfg_data;
        REG_HINV_Z: hz_r <= cfg_data;
        REG_SIZE_X: sx_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y: sy_r <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z: sz_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  vgdc_front #(.MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_cell_x, .in_cell_y, .in_cell_z,
    .in_vec_x, .in_vec_y, .in_vec_z, .size_x(sx_r), .size_y(sy_r), .size_z(sz_r),
    .q_valid, .q_ready, .q_word
  );

  vgdc_back #(.MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_word, .hinv_x(hx_r), .hinv_y(hy_r), .hinv_z(hz_r),
    .out_valid, .out_ready, .out_divergence, .out_curl_x, .out_curl_y, .out_curl_z,
    .out_index_error, .out_saturated
  );

  a_err_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_divergence == '0 && !out_saturated)
    else $error("index error with data");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_divergence))
    else $error("result changed while stalled");

endmodule
